[hw/rtl/hnorm_pkg.sv]
// ----------------------------------------------------------------------------
// hnorm_pkg
// Shared constants and types of the height map normal generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hnorm_pkg;

   // default map limits (line store size, row counter range)
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_DEPTH_DEFAULT = 4096;

   // register reset values
   localparam logic [10:0] MAP_WIDTH_RESET = 11'd1024;
   localparam logic [12:0] MAP_DEPTH_RESET = 13'd1024;

   // register indexes on the config port
   localparam logic REG_MAP_WIDTH = 1'b0;
   localparam logic REG_MAP_DEPTH = 1'b1;

   // input opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // normalizer widths: component magnitude, sum of squares, Q1.15 result
   localparam int MAG_W = 11;
   localparam int SUM_W = 21;
   localparam int Q15_W = 16;

   // request into the shared normalizer
   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mag_a;
      logic [SUM_W-1:0] sum_sq;
   } unit_req_type;

   // status out of the shared normalizer
   typedef struct packed {
      logic             done;
      logic [Q15_W-1:0] mag;
   } unit_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/hnorm_req_if.sv]
// ----------------------------------------------------------------------------
// hnorm_req_if
// Input channel: height samples and flush commands, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnorm_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] height;

   modport source (output valid, output op, output height, input ready);
   modport sink   (input valid, input op, input height, output ready);
endinterface

`default_nettype wire

[hw/rtl/hnorm_rsp_if.sv]
// ----------------------------------------------------------------------------
// hnorm_rsp_if
// Result channel: one unit normal with its grid position, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnorm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic [9:0]         column;
   logic [11:0]        row;
   logic               last;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output column, output row, output last, input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input column, input row, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/hnorm_line_store.sv]
// ----------------------------------------------------------------------------
// hnorm_line_store
// Three-row height line buffer, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hnorm_line_store #(
   parameter int MAX_WIDTH = hnorm_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(3*MAX_WIDTH)-1:0]  wr_addr,
   input  wire logic [7:0]                      wr_data,
   input  wire logic [$clog2(3*MAX_WIDTH)-1:0]  rd_addr,
   output logic      [7:0]                      rd_data
);
   localparam int DEPTH = 3 * MAX_WIDTH;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

[hw/rtl/hnorm_q15_unit.sv]
// ----------------------------------------------------------------------------
// hnorm_q15_unit
// Shared normalizer: magnitude of a/sqrt(s) in Q1.15, rounded to nearest.
// Computes Q = floor(a*a*2^32 / s) one quotient bit a cycle, then
// r = isqrt(Q) one root bit a cycle; result is (r+1)/2 saturated to 32767.
// ----------------------------------------------------------------------------
`default_nettype none

module hnorm_q15_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hnorm_pkg::unit_req_type unit_req,
   output hnorm_pkg::unit_rsp_type    unit_rsp
);
   localparam int SW = hnorm_pkg::SUM_W;
   localparam int AW = hnorm_pkg::MAG_W;
   localparam int QW = 33;   // quotient bits, Q <= 2^32
   localparam int RW = 17;   // root bits, r <= 65536

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_SQR  = 5'b00010,
      U_DIV  = 5'b00100,
      U_ROOT = 5'b01000,
      U_DONE = 5'b10000
   } ustate_type;

   ustate_type       state_ff, state_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [SW-1:0]    s_ff, s_in;
   logic             nlsb_ff, nlsb_in;
   logic [SW:0]      drem_ff, drem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [QW:0]      qs_ff, qs_in;
   logic [19:0]      srem_ff, srem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [15:0]      mag_ff, mag_in;

   logic [2*AW-1:0]  a_sq;
   logic [SW:0]      dshift;
   logic             dbit;
   logic [QW-1:0]    quo_next;
   logic [19:0]      sshift;
   logic [19:0]      trial;
   logic             sbit;
   logic [RW-1:0]    root_next;
   logic [RW:0]      root_p1;

   assign a_sq = {{AW{1'b0}}, a_ff} * {{AW{1'b0}}, a_ff};

   // one restoring division step; only the first step brings in a numerator bit
   always_comb begin
      dshift   = {drem_ff[SW-1:0], (cnt_ff == 6'd0) ? nlsb_ff : 1'b0};
      dbit     = (dshift >= {1'b0, s_ff});
      quo_next = {quo_ff[QW-2:0], dbit};
   end

   // one restoring square root step on two radicand bits
   always_comb begin
      sshift    = {srem_ff[17:0], qs_ff[QW:QW-1]};
      trial     = {1'b0, root_ff, 2'b01};
      sbit      = (sshift >= trial);
      root_next = {root_ff[RW-2:0], sbit};
      root_p1   = {1'b0, root_next} + {{RW{1'b0}}, 1'b1};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      s_in     = s_ff;
      nlsb_in  = nlsb_ff;
      drem_in  = drem_ff;
      quo_in   = quo_ff;
      qs_in    = qs_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      mag_in   = mag_ff;
      case (state_ff)
         U_IDLE: begin
            if (unit_req.start) begin
               a_in = unit_req.mag_a;
               s_in = unit_req.sum_sq;
               if (unit_req.mag_a == '0) begin
                  mag_in   = '0;
                  state_in = U_DONE;
               end else begin
                  state_in = U_SQR;
               end
            end
         end
         U_SQR: begin
            drem_in  = {1'b0, a_sq[2*AW-1:1]};
            nlsb_in  = a_sq[0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            drem_in = dbit ? (dshift - {1'b0, s_ff}) : dshift;
            quo_in  = quo_next;
            if (cnt_ff == 6'(QW - 1)) begin
               qs_in    = {1'b0, quo_next};
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = U_ROOT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         U_ROOT: begin
            srem_in = sbit ? (sshift - trial) : sshift;
            root_in = root_next;
            qs_in   = {qs_ff[QW-2:0], 2'b00};
            if (cnt_ff == 6'(RW - 1)) begin
               // (r+1)/2 of 32768 or more saturates
               mag_in   = root_p1[RW-1] ? 16'd32767 : root_p1[16:1];
               state_in = U_DONE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      s_ff    <= s_in;
      nlsb_ff <= nlsb_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      qs_ff   <= qs_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      mag_ff  <= mag_in;
   end

   assign unit_rsp.done = (state_ff == U_DONE);
   assign unit_rsp.mag  = mag_ff;
endmodule

`default_nettype wire

[hw/rtl/heightmap_normal_generator.sv]
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Streaming unit normals of a height map from central differences.
// A sample that releases a normal passes through decode, five line store
// reads, vector and sum-of-squares steps, three normalizer passes, emit and
// store; a flush that releases one skips the store. Other items end at decode
// or go from decode to store. Emit waits only while the output register
// still holds an untaken result. Synchronous active-high reset clears control;
// registers go to width 1024, depth 1024. The line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_normal_generator #(
   parameter int MAX_WIDTH = hnorm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_DEPTH = hnorm_pkg::MAX_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hnorm_req_if.sink        req_chan,
   hnorm_rsp_if.source      rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_DEPTH);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = $clog2(3 * MAX_WIDTH);
   localparam int MW = hnorm_pkg::MAG_W;
   localparam int SW = hnorm_pkg::SUM_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_DECIDE = 8'b00000010,
      S_READ   = 8'b00000100,
      S_VEC    = 8'b00001000,
      S_SUMSQ  = 8'b00010000,
      S_COMP   = 8'b00100000,
      S_EMIT   = 8'b01000000,
      S_WRITE  = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic               started_ff, started_in;
   logic               flush_ff, flush_in;
   logic               op_ff, op_in;
   logic [7:0]         hgt_ff, hgt_in;
   logic [CW-1:0]      in_col_ff, in_col_in;
   logic [RW-1:0]      in_row_ff, in_row_in;
   logic [1:0]         in_m3_ff, in_m3_in;
   logic [CW-1:0]      out_col_ff, out_col_in;
   logic [DW-1:0]      out_row_ff, out_row_in;
   logic [1:0]         out_m3_ff, out_m3_in;
   logic               map_done_ff, map_done_in;
   logic [10:0]        map_width_ff, map_width_in;
   logic [12:0]        map_depth_ff, map_depth_in;
   logic [7:0]         h_ff [5];
   logic [7:0]         h_in [5];
   logic signed [11:0] comp_ff [3];
   logic signed [11:0] comp_in [3];
   logic [SW-1:0]      sum_ff, sum_in;
   logic [15:0]        res_ff [3];
   logic [15:0]        res_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [9:0]         col_o_ff, col_o_in;
   logic [11:0]        row_o_ff, row_o_in;
   logic               last_o_ff, last_o_in;

   logic [WW-1:0]      w_eff;
   logic [DW-1:0]      d_eff;
   logic [WW-1:0]      c_p1, ic_p1;
   logic [DW-1:0]      r_p1, ir_p1;
   logic               has_l, has_r, has_d, has_u;
   logic               last_pt, emit_cond, cfg_wr;
   logic [CW-1:0]      col_l, col_r;
   logic [1:0]         m3_d, m3_u;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [7:0]         rd_data;
   logic               mem_we;
   logic [1:0]         dxx, dzz;
   logic [3:0]         prod;
   logic signed [11:0] diffx, diffz, vx, vy, vz;
   logic signed [11:0] comp_sel, comp_abs;
   logic [MW-1:0]      mag_sel;
   logic [2*MW-1:0]    mag_sq;
   logic [15:0]        res_signed;
   logic [31:0]        col_ext, row_ext;
   logic [CW-1:0]      adv_col;
   logic [DW-1:0]      adv_row;
   logic [1:0]         adv_m3;

   hnorm_pkg::unit_req_type unit_req;
   hnorm_pkg::unit_rsp_type unit_rsp;

   function automatic logic [AW-1:0] slot_addr(input logic [1:0] m3,
                                                input logic [CW-1:0] col);
      logic [AW-1:0] base;
      case (m3)
         2'd1:    base = AW'(MAX_WIDTH);
         2'd2:    base = AW'(2 * MAX_WIDTH);
         default: base = '0;
      endcase
      return base + AW'(col);
   endfunction

   function automatic logic [1:0] m3_next(input logic [1:0] m3);
      return (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
   endfunction

   // effective map size, clamped to [1, max]
   always_comb begin
      if (map_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(map_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(map_width_ff);
      end
      if (map_depth_ff == '0) begin
         d_eff = DW'(1);
      end else if (32'(map_depth_ff) > 32'(MAX_DEPTH)) begin
         d_eff = DW'(MAX_DEPTH);
      end else begin
         d_eff = DW'(map_depth_ff);
      end
   end

   // neighbor geometry of the output point
   always_comb begin
      c_p1    = WW'(out_col_ff) + WW'(1);
      r_p1    = out_row_ff + DW'(1);
      ic_p1   = WW'(in_col_ff) + WW'(1);
      ir_p1   = DW'(in_row_ff) + DW'(1);
      has_l   = (out_col_ff != '0);
      has_r   = (c_p1 < w_eff);
      has_d   = (out_row_ff != '0);
      has_u   = (r_p1 < d_eff);
      last_pt = (r_p1 == d_eff) && (c_p1 == w_eff);
      col_l   = has_l ? out_col_ff - CW'(1) : out_col_ff;
      col_r   = has_r ? c_p1[CW-1:0] : out_col_ff;
      m3_d    = has_d ? ((out_m3_ff == 2'd0) ? 2'd2 : out_m3_ff - 2'd1) : out_m3_ff;
      m3_u    = has_u ? m3_next(out_m3_ff) : out_m3_ff;
      emit_cond = (32'(in_row_ff) >= 32'd2) ||
                  ((32'(in_row_ff) == 32'd1) && (in_col_ff != '0));
      // output position advance
      if (c_p1 >= w_eff) begin
         adv_col = '0;
         adv_row = r_p1;
         adv_m3  = m3_next(out_m3_ff);
      end else begin
         adv_col = c_p1[CW-1:0];
         adv_row = out_row_ff;
         adv_m3  = out_m3_ff;
      end
      col_ext = 32'(out_col_ff);
      row_ext = 32'(out_row_ff);
   end

   // line store addressing: center, left, right, down, up
   always_comb begin
      case (step_ff)
         3'd1:    rd_addr = slot_addr(out_m3_ff, col_l);
         3'd2:    rd_addr = slot_addr(out_m3_ff, col_r);
         3'd3:    rd_addr = slot_addr(m3_d, out_col_ff);
         3'd4:    rd_addr = slot_addr(m3_u, out_col_ff);
         default: rd_addr = slot_addr(out_m3_ff, out_col_ff);
      endcase
      wr_addr = slot_addr(in_m3_ff, in_col_ff);
   end

   // scaled cross product
   always_comb begin
      dxx   = {1'b0, has_l} + {1'b0, has_r};
      dzz   = {1'b0, has_d} + {1'b0, has_u};
      diffx = $signed({4'b0, h_ff[2]}) - $signed({4'b0, h_ff[1]});
      diffz = $signed({4'b0, h_ff[4]}) - $signed({4'b0, h_ff[3]});
      case (dzz)
         2'd2:    vx = -(diffx <<< 1);
         2'd1:    vx = -diffx;
         default: vx = '0;
      endcase
      case (dxx)
         2'd2:    vz = -(diffz <<< 1);
         2'd1:    vz = -diffz;
         default: vz = '0;
      endcase
      prod = {2'b00, dzz} * {2'b00, dxx};
      vy   = $signed(({8'b0, prod} << 8) - {8'b0, prod});
   end

   // selected component magnitude and square
   always_comb begin
      comp_sel   = comp_ff[step_ff[1:0]];
      comp_abs   = comp_sel[11] ? -comp_sel : comp_sel;
      mag_sel    = comp_abs[MW-1:0];
      mag_sq     = {{MW{1'b0}}, mag_sel} * {{MW{1'b0}}, mag_sel};
      res_signed = comp_sel[11] ? 16'd0 - unit_rsp.mag : unit_rsp.mag;
   end

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      started_in   = started_ff;
      flush_in     = flush_ff;
      op_in        = op_ff;
      hgt_in       = hgt_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_m3_in     = in_m3_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_m3_in    = out_m3_ff;
      map_done_in  = map_done_ff;
      map_width_in = map_width_ff;
      map_depth_in = map_depth_ff;
      h_in         = h_ff;
      comp_in      = comp_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      col_o_in     = col_o_ff;
      row_o_in     = row_o_ff;
      last_o_in    = last_o_ff;
      mem_we       = 1'b0;
      unit_req.start  = 1'b0;
      unit_req.mag_a  = mag_sel;
      unit_req.sum_sq = sum_ff;

      // result taken downstream
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.op;
               hgt_in   = req_chan.height;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            step_in = '0;
            if (op_ff == hnorm_pkg::OP_FLUSH) begin
               if (!map_done_ff) begin
                  state_in = S_IDLE;
               end else if (out_row_ff >= d_eff) begin
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_m3_in    = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_m3_in   = '0;
                  map_done_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  flush_in = 1'b1;
                  state_in = S_READ;
               end
            end else begin
               flush_in = 1'b0;
               if (map_done_ff) begin
                  state_in = S_IDLE;
               end else if (emit_cond) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_READ: begin
            if (step_ff != 3'd0) begin
               h_in[step_ff - 3'd1] = rd_data;
            end
            if (step_ff == 3'd5) begin
               step_in  = '0;
               state_in = S_VEC;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_VEC: begin
            comp_in[0] = vx;
            comp_in[1] = vy;
            comp_in[2] = vz;
            sum_in     = '0;
            step_in    = '0;
            state_in   = S_SUMSQ;
         end
         S_SUMSQ: begin
            sum_in = sum_ff + SW'(mag_sq);
            if (step_ff == 3'd2) begin
               step_in    = '0;
               started_in = 1'b0;
               state_in   = S_COMP;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_COMP: begin
            if (!started_ff) begin
               unit_req.start = 1'b1;
               started_in     = 1'b1;
            end else if (unit_rsp.done) begin
               res_in[step_ff[1:0]] = res_signed;
               started_in = 1'b0;
               if (step_ff == 3'd2) begin
                  state_in = S_EMIT;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               nx_in        = res_ff[0];
               ny_in        = res_ff[1];
               nz_in        = res_ff[2];
               col_o_in     = col_ext[9:0];
               row_o_in     = row_ext[11:0];
               last_o_in    = last_pt;
               if (flush_ff && last_pt) begin
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_m3_in    = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_m3_in   = '0;
                  map_done_in = 1'b0;
               end else begin
                  out_col_in = adv_col;
                  out_row_in = adv_row;
                  out_m3_in  = adv_m3;
               end
               state_in = flush_ff ? S_IDLE : S_WRITE;
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            if (ic_p1 >= w_eff) begin
               in_col_in = '0;
               if (ir_p1 >= d_eff) begin
                  in_row_in   = '0;
                  in_m3_in    = '0;
                  map_done_in = 1'b1;
               end else begin
                  in_row_in = ir_p1[RW-1:0];
                  in_m3_in  = m3_next(in_m3_ff);
               end
            end else begin
               in_col_in = ic_p1[CW-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write restarts the map
      if (cfg_wr) begin
         if (csr_paddr[2] == hnorm_pkg::REG_MAP_WIDTH) begin
            map_width_in = csr_pwdata[10:0];
         end else begin
            map_depth_in = csr_pwdata[12:0];
         end
         in_col_in   = '0;
         in_row_in   = '0;
         in_m3_in    = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_m3_in   = '0;
         map_done_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         started_ff   <= 1'b0;
         flush_ff     <= 1'b0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_m3_ff     <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_m3_ff    <= '0;
         map_done_ff  <= 1'b0;
         map_width_ff <= hnorm_pkg::MAP_WIDTH_RESET;
         map_depth_ff <= hnorm_pkg::MAP_DEPTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         started_ff   <= started_in;
         flush_ff     <= flush_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_m3_ff     <= in_m3_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_m3_ff    <= out_m3_in;
         map_done_ff  <= map_done_in;
         map_width_ff <= map_width_in;
         map_depth_ff <= map_depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      hgt_ff    <= hgt_in;
      h_ff      <= h_in;
      comp_ff   <= comp_in;
      sum_ff    <= sum_in;
      res_ff    <= res_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      col_o_ff  <= col_o_in;
      row_o_ff  <= row_o_in;
      last_o_ff <= last_o_in;
   end

   hnorm_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (hgt_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hnorm_q15_unit u_q15_unit (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   // ports
   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.normal_x = $signed(nx_ff);
   assign rsp_chan.normal_y = $signed(ny_ff);
   assign rsp_chan.normal_z = $signed(nz_ff);
   assign rsp_chan.column   = col_o_ff;
   assign rsp_chan.row      = row_o_ff;
   assign rsp_chan.last     = last_o_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == hnorm_pkg::REG_MAP_WIDTH) ?
                       {21'b0, map_width_ff} : {19'b0, map_depth_ff};
endmodule

`default_nettype wire

[tb/heightmap_normal_generator_tb.sv]
// ----------------------------------------------------------------------------
// heightmap_normal_generator_tb
// Self-checking testbench of the height map normal generator. Height samples
// and flush commands are streamed through the request channel, while a local
// model of the line store and the normalizer predicts each unit normal and
// its grid position. Map size registers are rewritten over the APB port
// between phases. From the second test on, both channel sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_normal_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_W = hnorm_pkg::MAX_WIDTH_DEFAULT;
   localparam int ROWS_MAX = hnorm_pkg::MAX_DEPTH_DEFAULT;
   localparam logic [2:0] WIDTH_ADDR = {hnorm_pkg::REG_MAP_WIDTH, 2'b00};
   localparam logic [2:0] DEPTH_ADDR = {hnorm_pkg::REG_MAP_DEPTH, 2'b00};
   localparam int SETTLE_CYCLES = 250;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [9:0]         col;
      logic [11:0]        row;
      logic               last;
   } normal_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hnorm_req_if req_chan();
   hnorm_rsp_if rsp_chan();

   heightmap_normal_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // shared state
   normal_type  pending_normals[$];
   int          mismatches;
   int          items_sent;
   bit          tx_lazy;
   bit          rx_lazy;

   // --- map model ---
   logic [7:0]  line_mem [0:3*LINE_W-1];
   int unsigned cfg_width;
   int unsigned cfg_depth;
   int unsigned in_col, in_row, out_col, out_row;
   bit          map_full;

   function automatic int unsigned used_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > LINE_W) return LINE_W;
      return cfg_width;
   endfunction

   function automatic int unsigned used_depth();
      if (cfg_depth < 1) return 1;
      if (cfg_depth > ROWS_MAX) return ROWS_MAX;
      return cfg_depth;
   endfunction

   function automatic int height_of(int unsigned r, int unsigned c);
      return int'(line_mem[(r % 3) * LINE_W + c]);
   endfunction

   // round(32768*comp/sqrt(ss)), ties away from zero, saturated
   function automatic logic [15:0] unit_q15(int comp, longint unsigned ss);
      longint unsigned mag, goal, lo, hi, mid, t;
      mag = (comp < 0) ? longint'(-comp) : longint'(comp);
      lo = 0;
      hi = 32768;
      if (mag == 0 || ss == 0) return '0;
      goal = (65536 * mag) * (65536 * mag);
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (t * t * ss <= goal) lo = mid;
         else hi = mid - 1;
      end
      if (lo > 32767) lo = 32767;
      return (comp < 0) ? 16'(-lo) : 16'(lo);
   endfunction

   function automatic normal_type point_normal(int unsigned r, int unsigned c);
      int unsigned w, d;
      int h, hl, hr, hd, hu, sx, sz, vx, vy, vz;
      longint unsigned ss;
      normal_type n;
      w  = used_width();
      d  = used_depth();
      h  = height_of(r, c);
      hl = (c > 0) ? height_of(r, c - 1) : h;
      hr = (c + 1 < w) ? height_of(r, c + 1) : h;
      hd = (r > 0) ? height_of(r - 1, c) : h;
      hu = (r + 1 < d) ? height_of(r + 1, c) : h;
      sx = int'(c > 0) + int'(c + 1 < w);
      sz = int'(r > 0) + int'(r + 1 < d);
      vx = -sz * (hr - hl);
      vy = 255 * sz * sx;
      vz = -sx * (hu - hd);
      ss = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
      n.nx   = unit_q15(vx, ss);
      n.ny   = unit_q15(vy, ss);
      n.nz   = unit_q15(vz, ss);
      n.col  = c[9:0];
      n.row  = r[11:0];
      n.last = (r + 1 == d && c + 1 == w);
      return n;
   endfunction

   function automatic void restart_map();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; map_full = 0;
   endfunction

   function automatic void next_out_point();
      out_col++;
      if (out_col >= used_width()) begin
         out_col = 0;
         out_row++;
      end
   endfunction

   // model one accepted transfer
   function automatic void model_transfer(logic op, logic [7:0] hgt);
      normal_type n;
      if (op == hnorm_pkg::OP_FLUSH) begin
         if (!map_full) return;
         if (out_row >= used_depth()) begin
            restart_map();
            return;
         end
         n = point_normal(out_row, out_col);
         pending_normals = {pending_normals, n};
         if (n.last) restart_map();
         else next_out_point();
         return;
      end
      if (map_full) return;
      if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
         n = point_normal(out_row, out_col);
         pending_normals = {pending_normals, n};
         next_out_point();
      end
      if (in_col < LINE_W) line_mem[(in_row % 3) * LINE_W + in_col] = hgt;
      in_col++;
      if (in_col >= used_width()) begin
         in_col = 0;
         in_row++;
         if (in_row >= used_depth()) begin
            in_row = 0;
            map_full = 1;
         end
      end
   endfunction

   // --- stimulus helpers ---
   // ends at a falling edge with valid still high
   task automatic send_item(logic op, logic [7:0] hgt);
      int gap;
      gap = tx_lazy ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.op     <= op;
      req_chan.height <= hgt;
      do @(posedge clock); while (!req_chan.ready);
      model_transfer(op, hgt);
      items_sent++;
      @(negedge clock);
   endtask

   // wait for every expected normal, then let the block go idle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == WIDTH_ADDR) cfg_width = value & 32'h7FF;
      else cfg_depth = value & 32'h1FFF;
      restart_map();
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_map(int unsigned w, int unsigned d);
      drain();
      csr_write(WIDTH_ADDR, w);
      csr_write(DEPTH_ADDR, d);
   endtask

   task automatic flush_map();
      while (map_full) send_item(hnorm_pkg::OP_FLUSH, 8'($urandom));
   endtask

   // --- tests ---
   // 3x3 map with extreme heights, early flush and an ignored sample
   task automatic test_small_map();
      logic [7:0] peaks [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                8'd255, 8'd0, 8'd255};
      set_map(3, 3);
      send_item(hnorm_pkg::OP_FLUSH, 8'hFF);
      foreach (peaks[i]) send_item(hnorm_pkg::OP_SAMPLE, peaks[i]);
      send_item(hnorm_pkg::OP_SAMPLE, 8'hA5);
      flush_map();
      // next sample starts a new map with the same size
      send_item(hnorm_pkg::OP_SAMPLE, 8'd255);
   endtask

   // width or depth of one, also set as zero, gives degenerate vectors
   task automatic test_degenerate();
      set_map(1, 1);
      send_item(hnorm_pkg::OP_SAMPLE, 8'd200);
      flush_map();
      set_map(0, 4);
      repeat (4) send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
      flush_map();
      set_map(5, 0);
      repeat (5) send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
      flush_map();
   endtask

   // widest rows, cut short by the next size change
   task automatic test_wide_map();
      set_map(LINE_W, 2);
      repeat (LINE_W + 8) send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
      // hold off until the block has caught up
      drain();
      set_map(2047, 8191);
      repeat (20) send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
   endtask

   task automatic test_deep_map();
      set_map(1, ROWS_MAX);
      repeat (60) send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
   endtask

   // random small maps, mostly complete, some broken off or noisy
   task automatic test_random_maps(int target);
      int unsigned w, d, n, stop;
      bit extremes;
      while (items_sent < target) begin
         tx_lazy  = $urandom_range(0, 3) != 0;
         rx_lazy  = $urandom_range(0, 3) != 0;
         extremes = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 2) != 0 || !(in_col == 0 && in_row == 0 && !map_full)) begin
            w = $urandom_range(1, 9);
            d = $urandom_range(1, 8);
            set_map(w, d);
         end
         n = used_width() * used_depth();
         stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
         for (int i = 0; i < stop; i++) begin
            if ($urandom_range(0, 12) == 0)
               send_item(hnorm_pkg::OP_FLUSH, 8'($urandom));
            send_item(hnorm_pkg::OP_SAMPLE,
                      extremes ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                               : 8'($urandom));
         end
         if (stop == n) begin
            if ($urandom_range(0, 5) == 0)
               send_item(hnorm_pkg::OP_SAMPLE, 8'($urandom));
            flush_map();
         end
      end
   endtask

   // --- result checking ---
   initial begin
      normal_type got, want;
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = rx_lazy ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && !reset));
         got = '{rsp_chan.normal_x, rsp_chan.normal_y, rsp_chan.normal_z,
                 rsp_chan.column, rsp_chan.row, rsp_chan.last};
         if (pending_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected normal transfer: %p", got);
         end else begin
            want = pending_normals.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal wrong: expected %p, actual %p", want, got);
            end
         end
      end
   end

   // --- watchdog ---
   initial begin
      #20ms;
      $display("heightmap_normal_generator: mismatch");
      $finish;
   end

   // --- main sequence ---
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = hnorm_pkg::OP_SAMPLE;
      req_chan.height = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatches     = 0;
      items_sent     = 0;
      tx_lazy        = 1'b0;
      rx_lazy        = 1'b0;
      cfg_width      = hnorm_pkg::MAP_WIDTH_RESET;
      cfg_depth      = hnorm_pkg::MAP_DEPTH_RESET;
      foreach (line_mem[i]) line_mem[i] = '0;
      restart_map();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_small_map();
      tx_lazy = 1'b1;
      rx_lazy = 1'b1;
      test_degenerate();
      test_wide_map();
      test_deep_map();
      test_random_maps(items_sent + 200);

      drain();
      if (mismatches == 0 && pending_normals.size() == 0) begin
         $display("heightmap_normal_generator: match");
      end else begin
         $display("heightmap_normal_generator: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
